[rtl/pbr_pkg.sv]
// pbr_pkg: types and constants shared by the bisection root finder.
// No dependencies; imported by every module of the block.
`default_nettype none
package pbr_pkg;

    localparam int VAL_W   = 48;
    localparam int HALF_W  = VAL_W / 2;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int TOL_W   = 47;
    localparam int ITER_W  = 8;
    localparam int COEF_REGS = 5;
    localparam int IDX_W   = 3;

    typedef logic signed [VAL_W-1:0] t_val;

    localparam t_val VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_COEF_LAST = 3'd4;
    localparam logic [IDX_W-1:0] REG_TOL       = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAX_ITER  = 3'd6;

    // reset values
    localparam t_val RST_COEF_0 = -48'sd393970693;
    localparam t_val RST_COEF_1 = 48'sd405362235;
    localparam t_val RST_COEF_2 = 48'sd265964508;
    localparam t_val RST_COEF_3 = -48'sd375809638;
    localparam t_val RST_COEF_4 = 48'sd83886080;
    localparam logic [TOL_W-1:0]  RST_TOL      = 47'd168;
    localparam logic [ITER_W-1:0] RST_MAX_ITER = 8'd64;

    typedef struct packed {
        t_val interval_start;
        t_val interval_end;
    } t_in;

    typedef struct packed {
        t_val              root;
        logic              converged;
        logic [ITER_W-1:0] steps_used;
    } t_out;

    typedef struct packed {
        t_val [COEF_REGS-1:0] coef;
        logic [TOL_W-1:0]     tol;
        logic [ITER_W-1:0]    max_iter;
    } t_cfg;

endpackage
`default_nettype wire

[rtl/polynomial_bisection_root.sv]
// channel   | direction | handshake                 | beat
// ----------+-----------+---------------------------+------------------------------
// item      | in        | start & !busy             | i_item (interval_start/_end)
// result    | out       | o_done, one cycle         | o_result (root/converged/steps)
// config    | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One polynomial evaluation takes (COEF_COUNT-1) multiply-adds on the
// shared multiplier (launch, four partial products, saturate, done), and
// then the value is stored.
// An item costs two endpoint evaluations and a check, then one evaluation,
// update and check per step; the result strobe follows the last check.
// Reset clears the sequencer and loads the register defaults.
// busy is high from the accepted beat until the result strobe; results
// cannot be stalled.
// Depends on pbr_pkg, pbr_cfg, pbr_fxmul.
`default_nettype none
module polynomial_bisection_root
    import pbr_pkg::*;
#(
    parameter int COEF_COUNT = 5,
    parameter int FRAC_BITS  = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_in              i_item,
    output logic                  o_done,
    output t_out                  o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [VAL_W-1:0] i_cfg_data
);

    localparam logic [IDX_W-1:0] TOP_IDX   = IDX_W'(COEF_COUNT - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(COEF_COUNT - 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_EVDN  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;

    localparam logic [1:0] T_S = 2'd0;
    localparam logic [1:0] T_E = 2'd1;
    localparam logic [1:0] T_M = 2'd2;

    t_cfg cfg;

    pbr_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    logic [2:0]        r_state;
    logic [1:0]        r_tgt;
    logic [IDX_W-1:0]  r_idx;
    logic [ITER_W-1:0] r_steps;
    t_val              r_s, r_e, r_x, r_fs, r_fe, r_acc;

    logic mul_done;
    t_val mul_p;

    pbr_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_MUL),
        .i_a    (r_acc),
        .i_b    (r_x),
        .o_done (mul_done),
        .o_p    (mul_p)
    );

    logic [VAL_W:0]   add_sum, mid_sum;
    t_val             add_sat, mid;
    logic [VAL_W-1:0] mag_s, mag_e;
    logic             tol_s, tol_e, stop, opposite;

    always_comb begin
        add_sum = {mul_p[VAL_W-1], mul_p} + {cfg.coef[r_idx][VAL_W-1], cfg.coef[r_idx]};
        if (add_sum[VAL_W] != add_sum[VAL_W-1]) begin
            add_sat = add_sum[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            add_sat = add_sum[VAL_W-1:0];
        end
        // floor((s + e) / 2) from the exact 49-bit sum
        mid_sum = {r_s[VAL_W-1], r_s} + {r_e[VAL_W-1], r_e};
        mid     = mid_sum[VAL_W:1];
        mag_s   = r_fs[VAL_W-1] ? -r_fs : r_fs;
        mag_e   = r_fe[VAL_W-1] ? -r_fe : r_fe;
        tol_s   = mag_s <= {1'b0, cfg.tol};
        tol_e   = mag_e <= {1'b0, cfg.tol};
        stop    = tol_s || tol_e || (r_steps >= cfg.max_iter);
        // strictly opposite signs; zero never counts
        opposite = (r_fs[VAL_W-1] && !r_acc[VAL_W-1] && (r_acc != '0))
                || (r_acc[VAL_W-1] && !r_fs[VAL_W-1] && (r_fs != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_done) begin
                        r_state <= (r_idx == '0) ? S_EVDN : S_MUL;
                    end
                end
                S_EVDN: begin
                    r_state <= (r_tgt == T_S) ? S_MUL : S_CHECK;
                end
                S_CHECK: begin
                    if (stop) begin
                        r_state <= S_IDLE;
                        o_done  <= 1'b1;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_s     <= i_item.interval_start;
                r_e     <= i_item.interval_end;
                r_x     <= i_item.interval_start;
                r_tgt   <= T_S;
                r_acc   <= cfg.coef[TOP_IDX];
                r_idx   <= FIRST_IDX;
                r_steps <= '0;
            end
            S_WAIT: begin
                if (mul_done) begin
                    r_acc <= add_sat;
                    if (r_idx != '0) begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
            end
            S_EVDN: begin
                r_idx <= FIRST_IDX;
                case (r_tgt)
                    T_S: begin
                        r_fs  <= r_acc;
                        r_x   <= r_e;
                        r_tgt <= T_E;
                        r_acc <= cfg.coef[TOP_IDX];
                    end
                    T_E: begin
                        r_fe <= r_acc;
                    end
                    default: begin
                        if (opposite) begin
                            r_e  <= r_x;
                            r_fe <= r_acc;
                        end else begin
                            r_s  <= r_x;
                            r_fs <= r_acc;
                        end
                        r_steps <= r_steps + 1'b1;
                    end
                endcase
            end
            S_CHECK: begin
                r_x   <= mid;
                r_tgt <= T_M;
                r_acc <= cfg.coef[TOP_IDX];
                r_idx <= FIRST_IDX;
                o_result.root       <= tol_s ? r_s : r_e;
                o_result.converged  <= tol_s || tol_e;
                o_result.steps_used <= r_steps;
            end
            default: begin
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe outside end of work");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.converged |-> o_result.steps_used == cfg.max_iter)
        else $error("unconverged result before step cap");
    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.steps_used <= cfg.max_iter)
        else $error("more steps than the cap");

endmodule
`default_nettype wire

[rtl/pbr_cfg.sv]
// pbr_cfg: configuration register file (coefficients, tolerance, step cap).
// Depends on pbr_pkg.
`default_nettype none
module pbr_cfg
    import pbr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [VAL_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef[0]  <= RST_COEF_0;
            r_cfg.coef[1]  <= RST_COEF_1;
            r_cfg.coef[2]  <= RST_COEF_2;
            r_cfg.coef[3]  <= RST_COEF_3;
            r_cfg.coef[4]  <= RST_COEF_4;
            r_cfg.tol      <= RST_TOL;
            r_cfg.max_iter <= RST_MAX_ITER;
        end else if (i_we) begin
            if (i_idx <= REG_COEF_LAST) begin
                r_cfg.coef[i_idx] <= i_data;
            end else if (i_idx == REG_TOL) begin
                r_cfg.tol <= i_data[TOL_W-1:0];
            end else if (i_idx == REG_MAX_ITER) begin
                r_cfg.max_iter <= i_data[ITER_W-1:0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/pbr_fxmul.sv]
// pbr_fxmul: iterative saturating fixed-point multiply, one 24x24 partial
// product per cycle into a 96-bit accumulator. Depends on pbr_pkg.
`default_nettype none
module pbr_fxmul
    import pbr_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_val i_a,
    input  wire t_val i_b,
    output logic      o_done,
    output t_val      o_p
);

    logic              r_run, r_fin, r_neg;
    logic [1:0]        r_pp;
    logic [VAL_W-1:0]  r_ma, r_mb;
    logic [PROD_W-1:0] r_acc;

    logic [HALF_W-1:0]  pa, pb;
    logic [VAL_W-1:0]   pprod;
    logic [PROD_W-1:0]  pterm;
    logic [PROD_W-1:0]  shifted;
    logic [PROD_W-1:0]  limit;
    logic               sat;
    t_val               res;

    always_comb begin
        pa    = r_pp[1] ? r_ma[VAL_W-1:HALF_W] : r_ma[HALF_W-1:0];
        pb    = r_pp[0] ? r_mb[VAL_W-1:HALF_W] : r_mb[HALF_W-1:0];
        pprod = VAL_W'(pa) * VAL_W'(pb);
        // weight of the partial product: 0, one half or two halves
        case (r_pp)
            2'd0:    pterm = PROD_W'(pprod);
            2'd3:    pterm = PROD_W'(pprod) << (2 * HALF_W);
            default: pterm = PROD_W'(pprod) << HALF_W;
        endcase
        shifted = r_acc >> FRAC_BITS;
        limit   = r_neg ? (PROD_W'(1) << (VAL_W - 1)) : PROD_W'(VAL_MAX);
        sat     = shifted > limit;
        if (sat) begin
            res = r_neg ? VAL_MIN : VAL_MAX;
        end else begin
            res = r_neg ? -shifted[VAL_W-1:0] : shifted[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_fin;
            r_fin  <= r_run && (r_pp == 2'd3);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_pp == 2'd3) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
            r_ma  <= i_a[VAL_W-1] ? -i_a : i_a;
            r_mb  <= i_b[VAL_W-1] ? -i_b : i_b;
            r_acc <= '0;
            r_pp  <= 2'd0;
        end else if (r_run) begin
            r_acc <= r_acc + pterm;
            r_pp  <= r_pp + 2'd1;
        end
        if (r_fin) begin
            o_p <= res;
        end
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("multiply done held two cycles");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run && !r_fin)
        else $error("multiply restarted while running");
    a_fin_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> $past(r_run))
        else $error("multiply finished without running");

endmodule
`default_nettype wire
